// ===== rtl/tedu_pkg.sv =====
package tedu_pkg;

    // one input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       part_last;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       run_last;
        logic       part_end;
    } out_item_t;

    // decode_mode values; the spare code decodes as pass-through
    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_B64   = 2'd1;
    localparam logic [1:0] MODE_QP    = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int unsigned MaxResults = 3;
    localparam int unsigned CntW       = 2;

    // all results caused by one input item, oldest in slot 0
    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [CntW-1:0]            cnt;
        logic                       has_byte;
        logic                       part_end;
    } bundle_t;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = $clog2(QDepth);
    localparam int unsigned QCntW  = $clog2(QDepth + 1);

endpackage

// ===== rtl/tedu_front.sv =====
module tedu_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_data,
    input  logic                src_valid,
    output logic                src_stall,
    input  tedu_pkg::in_item_t  src_item,
    input  logic                q_full,
    output logic                push,
    output tedu_pkg::bundle_t   push_bundle
);

    localparam logic [1:0] QP_IDLE = 2'd0;
    localparam logic [1:0] QP_EQ   = 2'd1;
    localparam logic [1:0] QP_HEX  = 2'd2;
    localparam logic [1:0] QP_CR   = 2'd3;

    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = (c | 8'h20) - 8'h57;
        if (c inside {[8'h30:8'h39]})
            hex_val = c[3:0];
        else
            hex_val = t[3:0];
    endfunction

    // msb set when the byte is in the base64 alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        sextet_of = 7'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            t = c - 8'h41;
            sextet_of = {1'b1, t[5:0]};
        end else if (c inside {[8'h61:8'h7A]}) begin
            t = c - 8'h61 + 8'd26;
            sextet_of = {1'b1, t[5:0]};
        end else if (c inside {[8'h30:8'h39]}) begin
            t = c - 8'h30 + 8'd52;
            sextet_of = {1'b1, t[5:0]};
        end else if (c == 8'h2B) begin
            sextet_of = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            sextet_of = {1'b1, 6'd63};
        end
    endfunction

    logic [1:0]  mode_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic [11:0] sbuf_reg, sbuf_next;
    logic [2:0]  bits_reg, bits_next;
    logic        pad_reg, pad_next;

    logic        accept;

    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;
    assign push      = accept;

    always_comb
    begin
        logic [7:0] b;
        logic [7:0] e [4];
        logic [1:0] n;
        logic [6:0] sx;
        logic [3:0] sum;
        logic       do_idle;
        b          = src_item.in_byte;
        e[0]       = 8'h00;
        e[1]       = 8'h00;
        e[2]       = 8'h00;
        e[3]       = 8'h00;
        n          = 2'd0;
        sx         = sextet_of(b);
        sum        = {1'b0, bits_reg} + 4'd6;
        do_idle    = 1'b0;
        phase_next = phase_reg;
        held_next  = held_reg;
        sbuf_next  = sbuf_reg;
        bits_next  = bits_reg;
        pad_next   = pad_reg;

        if (mode_reg == tedu_pkg::MODE_B64) begin
            if (!pad_reg) begin
                if (b == CH_EQ) begin
                    pad_next = 1'b1;
                end else if (sx[6]) begin
                    sbuf_next = {sbuf_reg[5:0], sx[5:0]};
                    if (sum >= 4'd8) begin
                        e[n] = 8'(sbuf_next >> sum[2:0]);
                        n    = n + 2'd1;
                    end
                    bits_next = sum[2:0];
                end
            end
        end else if (mode_reg == tedu_pkg::MODE_QP) begin
            case (phase_reg)
                QP_IDLE: do_idle = 1'b1;
                QP_EQ:
                begin
                    if (b == CH_CR) begin
                        phase_next = QP_CR;
                    end else if (b == CH_LF) begin
                        phase_next = QP_IDLE;
                    end else if (is_hex(b)) begin
                        held_next  = b;
                        phase_next = QP_HEX;
                    end else begin
                        e[n]       = CH_EQ;
                        n          = n + 2'd1;
                        phase_next = QP_IDLE;
                        do_idle    = 1'b1;
                    end
                end
                QP_HEX:
                begin
                    phase_next = QP_IDLE;
                    if (is_hex(b)) begin
                        e[n] = {hex_val(held_reg), hex_val(b)};
                        n    = n + 2'd1;
                    end else begin
                        e[n] = CH_EQ;
                        n    = n + 2'd1;
                        e[n] = held_reg;
                        n    = n + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                QP_CR:
                begin
                    phase_next = QP_IDLE;
                    do_idle    = (b != CH_LF);
                end
                default: do_idle = 1'b1;
            endcase
            if (do_idle) begin
                if (b == CH_EQ) begin
                    phase_next = QP_EQ;
                end else begin
                    e[n] = b;
                    n    = n + 2'd1;
                end
            end
        end else begin
            e[n] = b;
            n    = n + 2'd1;
        end

        if (src_item.part_last) begin
            // flush an unfinished escape literally
            if (mode_reg == tedu_pkg::MODE_QP) begin
                if (phase_next == QP_EQ) begin
                    e[n] = CH_EQ;
                    n    = n + 2'd1;
                end else if (phase_next == QP_HEX) begin
                    e[n] = CH_EQ;
                    n    = n + 2'd1;
                    e[n] = held_next;
                    n    = n + 2'd1;
                end
            end
            phase_next = QP_IDLE;
            held_next  = 8'h00;
            sbuf_next  = 12'h000;
            bits_next  = 3'd0;
            pad_next   = 1'b0;
        end

        push_bundle.bytes    = {e[2], e[1], e[0]};
        push_bundle.part_end = src_item.part_last;
        if (n == 2'd0) begin
            push_bundle.cnt      = 2'd1;
            push_bundle.has_byte = 1'b0;
        end else begin
            push_bundle.cnt      = n;
            push_bundle.has_byte = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= tedu_pkg::MODE_PASS;
            phase_reg <= QP_IDLE;
            held_reg  <= 8'h00;
            sbuf_reg  <= 12'h000;
            bits_reg  <= 3'd0;
            pad_reg   <= 1'b0;
        end else begin
            if (cfg_we)
                mode_reg <= cfg_data;
            if (accept) begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                sbuf_reg  <= sbuf_next;
                bits_reg  <= bits_next;
                pad_reg   <= pad_next;
            end
        end
    end

endmodule

// ===== rtl/tedu_queue.sv =====
module tedu_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tedu_pkg::bundle_t push_bundle,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output tedu_pkg::bundle_t head
);

    tedu_pkg::bundle_t slot_reg [tedu_pkg::QDepth];

    logic [tedu_pkg::QPtrW-1:0] wr_reg, rd_reg;
    logic [tedu_pkg::QCntW-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == tedu_pkg::QCntW'(tedu_pkg::QDepth));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + tedu_pkg::QCntW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - tedu_pkg::QCntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push)
                wr_reg <= wr_reg + tedu_pkg::QPtrW'(1);
            if (pop)
                rd_reg <= rd_reg + tedu_pkg::QPtrW'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_bundle;
    end

endmodule

// ===== rtl/tedu_back.sv =====
module tedu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  tedu_pkg::bundle_t   head,
    output logic                pop,
    output logic                dst_valid,
    input  logic                dst_stall,
    output tedu_pkg::out_item_t dst_item
);

    logic [tedu_pkg::CntW-1:0] idx_reg, idx_next;
    logic                      valid_reg;
    tedu_pkg::out_item_t       out_reg, out_next;
    logic                      load;
    logic                      run_end;
    logic [7:0]                cur_byte;

    // output register takes a new result from a non-empty queue whenever it is empty or being taken
    assign load    = (!valid_reg || !dst_stall) && !empty;
    assign run_end = (idx_reg == head.cnt - 2'd1);
    assign pop     = load && run_end;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = head.bytes[0];
            2'd1:    cur_byte = head.bytes[1];
            2'd2:    cur_byte = head.bytes[2];
            default: cur_byte = 8'h00;
        endcase
        out_next.data_byte = cur_byte;
        out_next.has_byte  = head.has_byte;
        out_next.run_last  = run_end;
        out_next.part_end  = run_end && head.part_end;
        idx_next = run_end ? '0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg   <= idx_next;
                valid_reg <= 1'b1;
            end else if (!dst_stall) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

    assign dst_valid = valid_reg;
    assign dst_item  = out_reg;

endmodule

// ===== rtl/transfer_encoding_decoder_unit.sv =====
// channel   direction  payload     handshake
// src       in         in_item_t   src_valid / src_stall
// dst       out        out_item_t  dst_valid / dst_stall
// cfg       in         decode_mode cfg_we / cfg_data
//
// the front decodes one item per cycle into a bundle of one to three results
// and pushes it into a four-entry queue; the back sends one result per cycle
// unless dst_stall, through a registered output; items with one result each
// flow at one per cycle unless dst_stall; src_stall rises only when the
// queue is full. reset (rst_n, async) clears all decode state and the mode
module transfer_encoding_decoder_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_data,
    input  logic                src_valid,
    output logic                src_stall,
    input  tedu_pkg::in_item_t  src_item,
    output logic                dst_valid,
    input  logic                dst_stall,
    output tedu_pkg::out_item_t dst_item
);

    logic              q_full;
    logic              q_empty;
    logic              push;
    logic              pop;
    tedu_pkg::bundle_t push_bundle;
    tedu_pkg::bundle_t head;

    tedu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .src_item    (src_item),
        .q_full      (q_full),
        .push        (push),
        .push_bundle (push_bundle)
    );

    tedu_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .full        (q_full),
        .pop         (pop),
        .empty       (q_empty),
        .head        (head)
    );

    tedu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head      (head),
        .pop       (pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

endmodule

// ===== tb/sv/transfer_encoding_decoder_unit_test.sv =====
module transfer_encoding_decoder_unit_test;

    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;

    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 120;

    typedef enum logic [1:0] {QP_IDLE, QP_EQ, QP_EQ_HEX, QP_EQ_CR} qp_phase_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [1:0]          cfg_data  = 2'd0;
    logic                src_valid = 1'b0;
    logic                src_stall;
    tedu_pkg::in_item_t  src_item  = '0;
    logic                dst_valid;
    logic                dst_stall = 1'b0;
    tedu_pkg::out_item_t dst_item;

    transfer_encoding_decoder_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    tedu_pkg::in_item_t  encoded_items[$];
    tedu_pkg::out_item_t decoded_results[$];
    logic [7:0]          plain_bytes[$];
    int                  error_count  = 0;
    int                  items_queued = 0;

    // decoder state as the block should hold it
    logic [1:0]  mode_now   = tedu_pkg::MODE_PASS;
    qp_phase_t   qp_phase   = QP_IDLE;
    logic [7:0]  held_digit = 8'h00;
    logic [11:0] sextet_buf = 12'h000;
    logic [2:0]  bits_held  = 3'd0;
    logic        pad_flag   = 1'b0;

    function automatic bit is_hex_digit(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_nibble(logic [7:0] c);
        logic [7:0] folded;
        if (c >= "0" && c <= "9")
            return c[3:0];
        folded = c | 8'h20;
        return 4'(folded - "a" + 8'd10);
    endfunction

    function automatic int b64_sextet(logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return int'(c) - int'("A");
        if (c >= "a" && c <= "z")
            return int'(c) - int'("a") + 26;
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0") + 52;
        if (c == "+")
            return 62;
        if (c == "/")
            return 63;
        return -1;
    endfunction

    task automatic add_plain(logic [7:0] b);
        plain_bytes = {plain_bytes, b};
    endtask

    task automatic qp_plain(logic [7:0] b);
        if (b == CH_EQ)
            qp_phase = QP_EQ;
        else
            add_plain(b);
    endtask

    task automatic decode_item(tedu_pkg::in_item_t it);
        logic [7:0]          b;
        int                  v;
        int                  total;
        tedu_pkg::out_item_t r;
        b = it.in_byte;
        plain_bytes.delete();
        case (mode_now)
            tedu_pkg::MODE_B64:
            begin
                if (!pad_flag)
                begin
                    v = b64_sextet(b);
                    if (b == CH_EQ)
                        pad_flag = 1'b1;
                    else if (v >= 0)
                    begin
                        sextet_buf = {sextet_buf[5:0], 6'(v)};
                        total = int'(bits_held) + 6;
                        if (total >= 8)
                        begin
                            total -= 8;
                            add_plain(8'(sextet_buf >> total));
                        end
                        bits_held = 3'(total);
                    end
                end
            end
            tedu_pkg::MODE_QP:
            begin
                case (qp_phase)
                    QP_EQ:
                    begin
                        if (b == CH_CR)
                            qp_phase = QP_EQ_CR;
                        else if (b == CH_LF)
                            qp_phase = QP_IDLE;
                        else if (is_hex_digit(b))
                        begin
                            held_digit = b;
                            qp_phase = QP_EQ_HEX;
                        end
                        else
                        begin
                            // broken escape: '=' goes out literally, byte decoded afresh
                            add_plain(CH_EQ);
                            qp_phase = QP_IDLE;
                            qp_plain(b);
                        end
                    end
                    QP_EQ_HEX:
                    begin
                        qp_phase = QP_IDLE;
                        if (is_hex_digit(b))
                            add_plain({hex_nibble(held_digit), hex_nibble(b)});
                        else
                        begin
                            add_plain(CH_EQ);
                            add_plain(held_digit);
                            qp_plain(b);
                        end
                    end
                    QP_EQ_CR:
                    begin
                        qp_phase = QP_IDLE;
                        if (b != CH_LF)
                            qp_plain(b);
                    end
                    default:
                        qp_plain(b);
                endcase
            end
            default:
                add_plain(b);
        endcase

        if (it.part_last)
        begin
            // flush a pending escape, then clear everything but the mode
            if (mode_now == tedu_pkg::MODE_QP && qp_phase == QP_EQ)
                add_plain(CH_EQ);
            else if (mode_now == tedu_pkg::MODE_QP && qp_phase == QP_EQ_HEX)
            begin
                add_plain(CH_EQ);
                add_plain(held_digit);
            end
            qp_phase   = QP_IDLE;
            held_digit = 8'h00;
            sextet_buf = 12'h000;
            bits_held  = 3'd0;
            pad_flag   = 1'b0;
        end

        if (plain_bytes.size() == 0)
        begin
            r = '0;
            r.run_last = 1'b1;
            r.part_end = it.part_last;
            decoded_results = {decoded_results, r};
        end
        for (int i = 0; i < plain_bytes.size(); i++)
        begin
            r.data_byte = plain_bytes[i];
            r.has_byte  = 1'b1;
            r.run_last  = (i == plain_bytes.size() - 1);
            r.part_end  = it.part_last && (i == plain_bytes.size() - 1);
            decoded_results = {decoded_results, r};
        end
    endtask

    // prediction on accepted inputs, checking on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        tedu_pkg::out_item_t want;
        if (!rst_n)
        begin
            mode_now   = tedu_pkg::MODE_PASS;
            qp_phase   = QP_IDLE;
            held_digit = 8'h00;
            sextet_buf = 12'h000;
            bits_held  = 3'd0;
            pad_flag   = 1'b0;
        end
        else
        begin
            if (src_valid && !src_stall)
                decode_item(src_item);
            if (dst_valid && !dst_stall)
            begin
                if (decoded_results.size() == 0)
                begin
                    $error("unexpected result item: data_byte %02h has_byte %0b",
                           dst_item.data_byte, dst_item.has_byte);
                    error_count++;
                end
                else
                begin
                    want = decoded_results.pop_front();
                    if (dst_item.data_byte !== want.data_byte)
                    begin
                        $error("data_byte: expected %02h, got %02h",
                               want.data_byte, dst_item.data_byte);
                        error_count++;
                    end
                    if (dst_item.has_byte !== want.has_byte)
                    begin
                        $error("has_byte: expected %0b, got %0b",
                               want.has_byte, dst_item.has_byte);
                        error_count++;
                    end
                    if (dst_item.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0b, got %0b",
                               want.run_last, dst_item.run_last);
                        error_count++;
                    end
                    if (dst_item.part_end !== want.part_end)
                    begin
                        $error("part_end: expected %0b, got %0b",
                               want.part_end, dst_item.part_end);
                        error_count++;
                    end
                end
            end
            if (cfg_we)
                mode_now = cfg_data;
        end
    end

    // sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_item  <= '0;
        end
        else if (!src_valid || !src_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                src_valid <= 1'b0;
            end
            else if (encoded_items.size() > 0)
            begin
                src_item  <= encoded_items.pop_front();
                src_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
            else
                src_valid <= 1'b0;
        end
    end

    // receiver: rotating stall pattern, rerolled now and then, plus long hold-offs
    int         cycle_count   = 0;
    int         inputs_seen   = 0;
    int         hold_left     = 0;
    int         holds_done    = 0;
    logic [7:0] stall_pattern = 8'h00;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dst_stall <= 1'b0;
        else
        begin
            cycle_count++;
            if (src_valid && !src_stall)
                inputs_seen++;
            // hold off long enough for the queue to fill and back up the input
            if (hold_left == 0 && encoded_items.size() >= 12 &&
                ((holds_done == 0 && inputs_seen >= 120) ||
                 (holds_done == 1 && inputs_seen >= 330)))
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (cycle_count % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pattern = 8'h00;
                    1: stall_pattern = 8'($urandom);
                    2: stall_pattern = 8'($urandom) | 8'($urandom);
                    default: stall_pattern = 8'($urandom) & 8'($urandom);
                endcase
            end
            else
                stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
            if (hold_left > 0)
            begin
                hold_left--;
                dst_stall <= 1'b1;
            end
            else
                dst_stall <= stall_pattern[0];
        end
    end

    task automatic queue_item(logic [7:0] b, bit last = 1'b0);
        tedu_pkg::in_item_t it;
        it.in_byte   = b;
        it.part_last = last;
        encoded_items = {encoded_items, it};
        items_queued++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (encoded_items.size() != 0 || src_valid || decoded_results.size() != 0);
    endtask

    task automatic write_mode(logic [1:0] m);
        wait_idle();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] b64_char();
        int v;
        v = $urandom_range(0, 63);
        if (v < 26)
            return 8'(int'("A") + v);
        if (v < 52)
            return 8'(int'("a") + v - 26);
        if (v < 62)
            return 8'(int'("0") + v - 52);
        return (v == 62) ? "+" : "/";
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
            return 8'(int'("0") + v);
        if (v < 16)
            return 8'(int'("A") + v - 10);
        return 8'(int'("a") + v - 16);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (is_hex_digit(c));
        return c;
    endfunction

    task automatic queue_noise_part();
        int n;
        n = $urandom_range(1, 12);
        repeat (n)
            queue_item(8'($urandom));
    endtask

    task automatic queue_b64_part();
        int groups;
        groups = $urandom_range(1, 6);
        repeat (4 * groups)
        begin
            // line breaks and stray bytes between symbols
            case ($urandom_range(0, 19))
                0: queue_item(CH_CR);
                1: queue_item(CH_LF);
                2: queue_item(CH_SP);
                3: queue_item(8'($urandom));
                default: ;
            endcase
            queue_item(b64_char());
        end
        case ($urandom_range(0, 3))
            1:
            begin
                repeat (2)
                    queue_item(b64_char());
                queue_item(CH_EQ);
                queue_item(CH_EQ);
            end
            2:
            begin
                repeat (3)
                    queue_item(b64_char());
                queue_item(CH_EQ);
            end
            3:
            begin
                // symbols after padding are dropped
                queue_item(CH_EQ);
                repeat (2)
                    queue_item(b64_char());
            end
            default: ;
        endcase
    endtask

    task automatic queue_qp_part();
        int         n;
        logic [7:0] c;
        n = $urandom_range(2, 14);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    do
                        c = 8'($urandom_range(32, 126));
                    while (c == CH_EQ);
                    queue_item(c);
                end
                3, 4:
                begin
                    queue_item(CH_EQ);
                    queue_item(hex_char());
                    queue_item(hex_char());
                end
                5:
                begin
                    queue_item(CH_EQ);
                    queue_item(CH_CR);
                    queue_item(CH_LF);
                end
                6:
                begin
                    queue_item(CH_EQ);
                    queue_item(CH_LF);
                end
                7:
                begin
                    queue_item(CH_EQ);
                    queue_item(CH_CR);
                    queue_item(8'($urandom));
                end
                8:
                begin
                    queue_item(CH_EQ);
                    queue_item(hex_char());
                    queue_item(non_hex_char());
                end
                default:
                begin
                    queue_item(CH_EQ);
                    queue_item(8'($urandom));
                end
            endcase
        end
    endtask

    initial
    begin
        logic [1:0] m;
        int         parts;
        int         first_random;
        bit         close;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // pass-through straight out of reset
        queue_item(8'h00);
        queue_item(8'hFF, 1'b1);

        write_mode(tedu_pkg::MODE_SPARE);
        queue_item(CH_EQ, 1'b1);

        // 62, 63, a stray line feed, a digit, padding, then an ignored symbol
        write_mode(tedu_pkg::MODE_B64);
        queue_item("+");
        queue_item("/");
        queue_item(CH_LF);
        queue_item("9");
        queue_item(CH_EQ);
        queue_item("a", 1'b1);

        write_mode(tedu_pkg::MODE_QP);
        queue_item(CH_EQ);
        queue_item(CH_CR);
        queue_item(CH_LF);
        queue_item(CH_EQ);
        queue_item(CH_LF);
        queue_item(CH_EQ);
        queue_item("g");
        // held digit broken by '=', which opens a fresh escape
        queue_item(CH_EQ);
        queue_item("A");
        queue_item(CH_EQ);
        queue_item("F");
        queue_item("a");
        queue_item(CH_EQ);
        queue_item(CH_CR);
        queue_item("y");
        queue_item(CH_EQ, 1'b1);
        queue_item(CH_EQ);
        queue_item("B", 1'b1);

        first_random = items_queued;
        while (items_queued < first_random + RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0: m = tedu_pkg::MODE_PASS;
                1: m = tedu_pkg::MODE_SPARE;
                2, 3, 4: m = tedu_pkg::MODE_B64;
                default: m = tedu_pkg::MODE_QP;
            endcase
            write_mode(m);
            parts = $urandom_range(1, 4);
            for (int p = 0; p < parts; p++)
            begin
                if ($urandom_range(0, 5) == 0 || m == tedu_pkg::MODE_PASS ||
                    m == tedu_pkg::MODE_SPARE)
                    queue_noise_part();
                else if (m == tedu_pkg::MODE_B64)
                    queue_b64_part();
                else
                    queue_qp_part();
                // the last part of a phase may stay open across the next mode change
                close = (p < parts - 1) || ($urandom_range(0, 2) != 0);
                if (close)
                    encoded_items[encoded_items.size() - 1].part_last = 1'b1;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== transfer_encoding_decoder_unit.f =====
rtl/tedu_pkg.sv
rtl/tedu_front.sv
rtl/tedu_queue.sv
rtl/tedu_back.sv
rtl/transfer_encoding_decoder_unit.sv
tb/sv/transfer_encoding_decoder_unit_test.sv
